// ----- rtl/core/mbet_pkg.sv -----
`default_nettype none

package mbet_pkg;

  // Fixed formats of the data path.
  localparam int unsigned MaxDim   = 4096;
  localparam int unsigned FracBits = 28;
  localparam int unsigned IterBits = 16;
  localparam int unsigned DimW     = 13;
  localparam int unsigned CoordW   = 12;
  localparam int unsigned IndexW   = 24;
  localparam int unsigned ValW     = 32;
  localparam int unsigned SqW      = 2 * ValW;
  localparam int unsigned SatW     = SqW + 2;
  // Magnitude of an axis span times a coordinate.
  localparam int unsigned ProdW    = ValW + CoordW;
  localparam int unsigned CfgIdxW  = 3;

  localparam logic [SqW-1:0] EscLimit = SqW'(4) << (2 * FracBits);

  // Register indexes of the configuration port.
  localparam logic [CfgIdxW-1:0] CFG_REAL_MIN  = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_REAL_MAX  = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_IMAG_MIN  = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_IMAG_MAX  = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_WIDTH     = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_HEIGHT    = 3'd5;
  localparam logic [CfgIdxW-1:0] CFG_MAX_ITER  = 3'd6;

  localparam logic [ValW-1:0]     RstRealMin = 32'hE000_0000;
  localparam logic [ValW-1:0]     RstRealMax = 32'h1000_0000;
  localparam logic [ValW-1:0]     RstImagMin = 32'hE800_0000;
  localparam logic [ValW-1:0]     RstImagMax = 32'h1800_0000;
  localparam logic [DimW-1:0]     RstWidth   = 13'd640;
  localparam logic [DimW-1:0]     RstHeight  = 13'd480;
  localparam logic [IterBits-1:0] RstMaxIter = 16'd256;

  typedef struct packed {
    logic [CoordW-1:0] x_coord;
    logic [CoordW-1:0] y_coord;
  } in_word_t;

  typedef struct packed {
    logic [IndexW-1:0]   pixel_index;
    logic [IterBits-1:0] iteration_count;
  } out_word_t;

  // A mapped point on its way from the front end to the iteration engine.
  typedef struct packed {
    logic [IndexW-1:0]      pixel_index;
    logic signed [ValW-1:0] c_re;
    logic signed [ValW-1:0] c_im;
  } point_t;

  typedef struct packed {
    logic signed [ValW-1:0] real_min;
    logic signed [ValW-1:0] real_max;
    logic signed [ValW-1:0] imag_min;
    logic signed [ValW-1:0] imag_max;
    logic [DimW-1:0]        image_width;
    logic [DimW-1:0]        image_height;
    logic [IterBits-1:0]    max_iterations;
  } cfg_t;

  // Saturates a wide signed value to the signed Q3.28 range.
  function automatic logic signed [ValW-1:0] sat_val(input logic signed [SatW-1:0] v);
    logic [SatW-ValW:0] top;
    top = v[SatW-1:ValW-1];
    if (top == '0 || top == '1) begin
      return $signed(v[ValW-1:0]);
    end else if (v[SatW-1]) begin
      return $signed({1'b1, {(ValW-1){1'b0}}});
    end else begin
      return $signed({1'b0, {(ValW-1){1'b1}}});
    end
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/mbet_fifo.sv -----
`default_nettype none

module mbet_fifo #(
  parameter int unsigned Depth = 2,
  parameter int unsigned Width = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] data_o,
  output logic             empty_o
);

  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW  = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [AddrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == AddrW'(Depth - 1)) ? '0 : wr_ptr_q + AddrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == AddrW'(Depth - 1)) ? '0 : rd_ptr_q + AddrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/mbet_div.sv -----
`default_nettype none

module mbet_div
  import mbet_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [ProdW-1:0] dividend_i,
  input  logic [DimW-1:0]  divisor_i,
  output logic             done_o,
  output logic [ProdW-1:0] quot_o
);

  localparam int unsigned CntW = $clog2(ProdW + 1);

  // The dividend shifts out at the top while quotient bits shift in at the bottom.
  logic [ProdW-1:0] quo_q, quo_d;
  logic [DimW-1:0]  rem_q, rem_d;
  logic [DimW-1:0]  dvs_q, dvs_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [DimW:0]    trial, diff;

  assign trial  = {rem_q, quo_q[ProdW-1]};
  assign diff   = trial - {1'b0, dvs_q};
  assign done_o = done_q;
  assign quot_o = quo_q;

  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      quo_d  = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
      cnt_d  = CntW'(ProdW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial >= {1'b0, dvs_q}) begin
        rem_d = diff[DimW-1:0];
        quo_d = {quo_q[ProdW-2:0], 1'b1};
      end else begin
        rem_d = trial[DimW-1:0];
        quo_d = {quo_q[ProdW-2:0], 1'b0};
      end
      cnt_d = cnt_q - CntW'(1);
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

endmodule

`default_nettype wire

// ----- rtl/core/mbet_front.sv -----
`default_nettype none

module mbet_front
  import mbet_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  in_word_t in_word_i,
  input  cfg_t     cfg_i,
  output logic     busy_o,
  input  logic     q_full_i,
  output logic     q_push_o,
  output point_t   q_data_o
);

  localparam logic [2:0] F_IDLE  = 3'd0;
  localparam logic [2:0] F_MUL   = 3'd1;
  localparam logic [2:0] F_START = 3'd2;
  localparam logic [2:0] F_DIV   = 3'd3;
  localparam logic [2:0] F_PUSH  = 3'd4;

  logic [2:0]             state_q, state_d;
  logic [CoordW-1:0]      x_q, x_d, y_q, y_d;
  logic [DimW-1:0]        w_q, w_d, h_q, h_d;
  logic [IndexW-1:0]      idx_q, idx_d;
  logic [ProdW-1:0]       mag_re_q, mag_re_d, mag_im_q, mag_im_d;
  logic                   neg_re_q, neg_re_d, neg_im_q, neg_im_d;
  logic signed [ValW-1:0] cre_q, cre_d, cim_q, cim_d;

  logic                   div_start, done_re, done_im, div_done;
  logic [ProdW-1:0]       quot_re, quot_im;
  logic [DimW-1:0]        w_cl, h_cl;
  logic signed [ValW:0]   span_re, span_im, abs_re, abs_im;
  logic [ValW+1:0]        off_re, off_im, sum_re, sum_im;
  logic [IndexW:0]        idx_full;

  function automatic logic [DimW-1:0] clamp_dim(input logic [DimW-1:0] d);
    if (d == '0) begin
      return DimW'(1);
    end else if (d > DimW'(MaxDim)) begin
      return DimW'(MaxDim);
    end else begin
      return d;
    end
  endfunction

  assign w_cl = clamp_dim(cfg_i.image_width);
  assign h_cl = clamp_dim(cfg_i.image_height);

  assign span_re = $signed({cfg_i.real_max[ValW-1], cfg_i.real_max})
                 - $signed({cfg_i.real_min[ValW-1], cfg_i.real_min});
  assign span_im = $signed({cfg_i.imag_max[ValW-1], cfg_i.imag_max})
                 - $signed({cfg_i.imag_min[ValW-1], cfg_i.imag_min});
  assign abs_re  = span_re[ValW] ? -span_re : span_re;
  assign abs_im  = span_im[ValW] ? -span_im : span_im;

  assign idx_full = (IndexW+1)'(y_q) * (IndexW+1)'(w_q) + (IndexW+1)'(x_q);

  // The quotient is below the span magnitude, so it fits in ValW bits.
  assign off_re = neg_re_q ? -{2'b00, quot_re[ValW-1:0]} : {2'b00, quot_re[ValW-1:0]};
  assign off_im = neg_im_q ? -{2'b00, quot_im[ValW-1:0]} : {2'b00, quot_im[ValW-1:0]};
  assign sum_re = {{2{cfg_i.real_min[ValW-1]}}, cfg_i.real_min} + off_re;
  assign sum_im = {{2{cfg_i.imag_min[ValW-1]}}, cfg_i.imag_min} + off_im;

  assign div_start = (state_q == F_START);
  assign div_done  = done_re & done_im;

  mbet_div u_div_re (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (mag_re_q),
    .divisor_i  (w_q),
    .done_o     (done_re),
    .quot_o     (quot_re)
  );

  mbet_div u_div_im (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (mag_im_q),
    .divisor_i  (h_q),
    .done_o     (done_im),
    .quot_o     (quot_im)
  );

  always_comb begin
    state_d  = state_q;
    x_d      = x_q;
    y_d      = y_q;
    w_d      = w_q;
    h_d      = h_q;
    idx_d    = idx_q;
    mag_re_d = mag_re_q;
    mag_im_d = mag_im_q;
    neg_re_d = neg_re_q;
    neg_im_d = neg_im_q;
    cre_d    = cre_q;
    cim_d    = cim_q;
    unique case (state_q)
      F_IDLE: begin
        if (push_i) begin
          w_d = w_cl;
          h_d = h_cl;
          x_d = (DimW'(in_word_i.x_coord) >= w_cl) ? CoordW'(w_cl - DimW'(1))
                                                   : in_word_i.x_coord;
          y_d = (DimW'(in_word_i.y_coord) >= h_cl) ? CoordW'(h_cl - DimW'(1))
                                                   : in_word_i.y_coord;
          state_d = F_MUL;
        end
      end
      F_MUL: begin
        idx_d    = idx_full[IndexW-1:0];
        mag_re_d = ProdW'(abs_re[ValW-1:0]) * ProdW'(x_q);
        mag_im_d = ProdW'(abs_im[ValW-1:0]) * ProdW'(y_q);
        neg_re_d = span_re[ValW];
        neg_im_d = span_im[ValW];
        state_d  = F_START;
      end
      F_START: begin
        state_d = F_DIV;
      end
      F_DIV: begin
        if (div_done) begin
          cre_d   = sat_val($signed({{(SatW-ValW-2){sum_re[ValW+1]}}, sum_re}));
          cim_d   = sat_val($signed({{(SatW-ValW-2){sum_im[ValW+1]}}, sum_im}));
          state_d = F_PUSH;
        end
      end
      F_PUSH: begin
        if (!q_full_i) begin
          state_d = F_IDLE;
        end
      end
      default: begin
        state_d = F_IDLE;
      end
    endcase
  end

  assign busy_o               = (state_q != F_IDLE);
  assign q_push_o             = (state_q == F_PUSH) && !q_full_i;
  assign q_data_o.pixel_index = idx_q;
  assign q_data_o.c_re        = cre_q;
  assign q_data_o.c_im        = cim_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q      <= x_d;
    y_q      <= y_d;
    w_q      <= w_d;
    h_q      <= h_d;
    idx_q    <= idx_d;
    mag_re_q <= mag_re_d;
    mag_im_q <= mag_im_d;
    neg_re_q <= neg_re_d;
    neg_im_q <= neg_im_d;
    cre_q    <= cre_d;
    cim_q    <= cim_d;
  end

endmodule

`default_nettype wire

// ----- rtl/core/mbet_core.sv -----
`default_nettype none

module mbet_core
  import mbet_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [IterBits-1:0] max_iter_i,
  input  logic                q_empty_i,
  input  point_t              q_data_i,
  output logic                q_pop_o,
  input  logic                r_full_i,
  output logic                r_push_o,
  output out_word_t           r_data_o
);

  localparam logic [1:0] B_IDLE = 2'd0;
  localparam logic [1:0] B_MUL  = 2'd1;
  localparam logic [1:0] B_CHK  = 2'd2;

  logic [1:0]                state_q, state_d;
  logic [IndexW-1:0]         idx_q, idx_d;
  logic signed [ValW-1:0]    cr_q, cr_d, ci_q, ci_d, zr_q, zr_d, zi_q, zi_d;
  logic [IterBits-1:0]       cnt_q, cnt_d;
  logic signed [SqW-1:0]     rr_q, rr_d, ii_q, ii_d, ri_q, ri_d;

  logic [SqW-1:0]            mag2;
  logic                      stop;
  logic signed [SqW-1:0]     dif, dif_sh, ri_sh;
  logic signed [SatW-1:0]    nr_w, ni_w;

  assign mag2   = rr_q + ii_q;
  assign stop   = (mag2 > EscLimit) || (cnt_q >= max_iter_i);
  assign dif    = rr_q - ii_q;
  // Arithmetic shifts round toward minus infinity.
  assign dif_sh = dif >>> FracBits;
  assign ri_sh  = ri_q >>> (FracBits - 1);
  assign nr_w   = $signed({{(SatW-SqW){dif_sh[SqW-1]}}, dif_sh})
                + $signed({{(SatW-ValW){cr_q[ValW-1]}}, cr_q});
  assign ni_w   = $signed({{(SatW-SqW){ri_sh[SqW-1]}}, ri_sh})
                + $signed({{(SatW-ValW){ci_q[ValW-1]}}, ci_q});

  // A point starts only when the result queue has room; only this unit fills it.
  assign q_pop_o  = (state_q == B_IDLE) && !q_empty_i && !r_full_i;
  assign r_push_o = (state_q == B_CHK) && stop;
  assign r_data_o.pixel_index     = idx_q;
  assign r_data_o.iteration_count = (cnt_q == max_iter_i) ? '0 : cnt_q;

  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    cr_d    = cr_q;
    ci_d    = ci_q;
    zr_d    = zr_q;
    zi_d    = zi_q;
    cnt_d   = cnt_q;
    rr_d    = rr_q;
    ii_d    = ii_q;
    ri_d    = ri_q;
    unique case (state_q)
      B_IDLE: begin
        if (q_pop_o) begin
          idx_d   = q_data_i.pixel_index;
          cr_d    = q_data_i.c_re;
          ci_d    = q_data_i.c_im;
          zr_d    = q_data_i.c_re;
          zi_d    = q_data_i.c_im;
          cnt_d   = IterBits'(1);
          state_d = B_MUL;
        end
      end
      B_MUL: begin
        rr_d    = SqW'(zr_q) * SqW'(zr_q);
        ii_d    = SqW'(zi_q) * SqW'(zi_q);
        ri_d    = SqW'(zr_q) * SqW'(zi_q);
        state_d = B_CHK;
      end
      B_CHK: begin
        if (stop) begin
          state_d = B_IDLE;
        end else begin
          zr_d    = sat_val(nr_w);
          zi_d    = sat_val(ni_w);
          cnt_d   = cnt_q + IterBits'(1);
          state_d = B_MUL;
        end
      end
      default: begin
        state_d = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= B_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
    cr_q  <= cr_d;
    ci_q  <= ci_d;
    zr_q  <= zr_d;
    zi_q  <= zi_d;
    cnt_q <= cnt_d;
    rr_q  <= rr_d;
    ii_q  <= ii_d;
    ri_q  <= ri_d;
  end

endmodule

`default_nettype wire

// ----- rtl/core/mandelbrot_escape_time_unit.sv -----
// Escape-time unit: takes one pixel coordinate word and returns one result word
// holding the linear pixel index and the escape count (0 for points in the set).
// Input side: a word is taken when push is high and full is low. Output side: the
// oldest result is shown while empty is low and leaves when pop is high.
// Configuration registers are written through cfg_we_i, cfg_idx_i and cfg_data_i.
// The user must write them only while no word is in flight; the block does not
// enforce this itself. The front end clamps the coordinate, multiplies the axis
// span and runs two bit-serial dividers (44 steps); it holds full high from taking
// a word until its point enters the point queue, so it takes one word at a time.
// The iteration engine loads a point, then runs each escape test as a product
// state (the three 32x32 products) and a check state (the compare and update); it
// takes a new point only after the result of the last one is pushed. The sustained
// throughput is set by the slower of the two. Reset restores the default viewport
// (-2..1, -1.5..1.5, 640x480, limit 256) and empties both queues. When the
// receiver stops popping, the result queue fills, the engine waits before taking
// a new point, the point queue fills and full stays high; no word is lost.
`default_nettype none

module mandelbrot_escape_time_unit
  import mbet_pkg::*;
#(
  parameter int unsigned MID_DEPTH = 2,
  parameter int unsigned RES_DEPTH = 4
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  in_word_t           in_word_i,
  output logic               empty,
  input  logic               pop,
  output out_word_t          out_word_o,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [ValW-1:0]    cfg_data_i
);

  cfg_t                        cfg_q, cfg_d;
  logic                        mid_push, mid_full, mid_pop, mid_empty;
  point_t                      mid_wdata, mid_rdata;
  logic [$bits(point_t)-1:0]   mid_rvec;
  logic                        res_push, res_full;
  out_word_t                   res_wdata;
  logic [$bits(out_word_t)-1:0] res_rvec;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_REAL_MIN: cfg_d.real_min       = $signed(cfg_data_i);
        CFG_REAL_MAX: cfg_d.real_max       = $signed(cfg_data_i);
        CFG_IMAG_MIN: cfg_d.imag_min       = $signed(cfg_data_i);
        CFG_IMAG_MAX: cfg_d.imag_max       = $signed(cfg_data_i);
        CFG_WIDTH:    cfg_d.image_width    = cfg_data_i[DimW-1:0];
        CFG_HEIGHT:   cfg_d.image_height   = cfg_data_i[DimW-1:0];
        CFG_MAX_ITER: cfg_d.max_iterations = cfg_data_i[IterBits-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.real_min       <= $signed(RstRealMin);
      cfg_q.real_max       <= $signed(RstRealMax);
      cfg_q.imag_min       <= $signed(RstImagMin);
      cfg_q.imag_max       <= $signed(RstImagMax);
      cfg_q.image_width    <= RstWidth;
      cfg_q.image_height   <= RstHeight;
      cfg_q.max_iterations <= RstMaxIter;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  mbet_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .in_word_i (in_word_i),
    .cfg_i     (cfg_q),
    .busy_o    (full),
    .q_full_i  (mid_full),
    .q_push_o  (mid_push),
    .q_data_o  (mid_wdata)
  );

  mbet_fifo #(
    .Depth (MID_DEPTH),
    .Width ($bits(point_t))
  ) u_mid_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (mid_push),
    .data_i  (mid_wdata),
    .full_o  (mid_full),
    .pop_i   (mid_pop),
    .data_o  (mid_rvec),
    .empty_o (mid_empty)
  );

  assign mid_rdata = point_t'(mid_rvec);

  mbet_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .max_iter_i (cfg_q.max_iterations),
    .q_empty_i  (mid_empty),
    .q_data_i   (mid_rdata),
    .q_pop_o    (mid_pop),
    .r_full_i   (res_full),
    .r_push_o   (res_push),
    .r_data_o   (res_wdata)
  );

  mbet_fifo #(
    .Depth (RES_DEPTH),
    .Width ($bits(out_word_t))
  ) u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res_wdata),
    .full_o  (res_full),
    .pop_i   (pop),
    .data_o  (res_rvec),
    .empty_o (empty)
  );

  assign out_word_o = out_word_t'(res_rvec);

  // The engine only starts a point when the result queue has a free slot.
  a_res_room : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push |-> !res_full)
    else $error("result written into a full result queue");

  a_mid_room : assert property (@(posedge clk_i) disable iff (!rst_ni)
    mid_push |-> !mid_full)
    else $error("point written into a full point queue");

  a_accept_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !full) |=> full)
    else $error("front end did not go busy after taking a word");

  a_pop_start : assert property (@(posedge clk_i) disable iff (!rst_ni)
    mid_pop |=> !res_push)
    else $error("engine finished a point in the cycle after loading it");

endmodule

`default_nettype wire
